@@ rtl/core/wvp_pkg.sv @@
// ----------------------------------------------------------------------------
// wvp_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package wvp_pkg;

    localparam logic [31:0] TAG_RIFF  = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE  = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA  = 32'h6174_6164;
    localparam logic [31:0] FMT_SIZE  = 32'd16;
    localparam logic [15:0] PCM_FMT   = 16'd1;
    localparam logic [15:0] BITS_8    = 16'd8;

    // byte positions of the last byte of each checked header field
    localparam logic [5:0] POS_RIFF_ID    = 6'd3;
    localparam logic [5:0] POS_CHUNK_SIZE = 6'd7;
    localparam logic [5:0] POS_WAVE_ID    = 6'd11;
    localparam logic [5:0] POS_FMT_ID     = 6'd15;
    localparam logic [5:0] POS_FMT_SIZE   = 6'd19;
    localparam logic [5:0] POS_AUDIO_FMT  = 6'd21;
    localparam logic [5:0] POS_CHANNELS   = 6'd23;
    localparam logic [5:0] POS_RATE       = 6'd27;
    localparam logic [5:0] POS_BYTE_RATE  = 6'd31;
    localparam logic [5:0] POS_ALIGN      = 6'd33;
    localparam logic [5:0] POS_BITS       = 6'd35;
    localparam logic [5:0] POS_DATA_ID    = 6'd39;
    localparam logic [5:0] POS_DATA_SIZE  = 6'd43;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_RIFF_ID    = 4'd0,
        ERR_CHUNK_SIZE = 4'd1,
        ERR_WAVE_ID    = 4'd2,
        ERR_FMT_ID     = 4'd3,
        ERR_FMT_SIZE   = 4'd4,
        ERR_AUDIO_FMT  = 4'd5,
        ERR_CHANNELS   = 4'd6,
        ERR_RATE       = 4'd7,
        ERR_BYTE_RATE  = 4'd8,
        ERR_ALIGN      = 4'd9,
        ERR_BITS       = 4'd10,
        ERR_DATA_ID    = 4'd11,
        ERR_DATA_SIZE  = 4'd12
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [15:0] sample_value;
        logic [3:0]         error_code;
        logic [1:0]         channel_count;
        logic [30:0]        rate_hz;
        logic [15:0]        sample_bits;
        logic [30:0]        payload_bytes;
        logic               last_sample;
    } out_item_t;

endpackage

@@ rtl/core/wvp_parse.sv @@
// ----------------------------------------------------------------------------
// wvp_parse
// Parser state and per-byte update: header checks, report and sample decode.
// ----------------------------------------------------------------------------
module wvp_parse
    import wvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  ch_reg, ch_next;
    logic [30:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [30:0] remain_reg, remain_next;
    logic [8:0]  pend_reg, pend_next;

    phase_t      phase_v;
    logic [5:0]  pos_v;
    logic [8:0]  pend_v;
    logic [31:0] acc_new;
    logic [15:0] half;
    logic        chk_err;
    err_t        chk_code;
    logic [32:0] min_byte_rate;
    logic [17:0] ch_bits;
    logic [30:0] remain_dec;
    logic [30:0] size_even;

    assign phase_v = item.file_start ? PH_HEADER : phase_reg;
    assign pos_v   = item.file_start ? 6'd0 : pos_reg;
    assign pend_v  = item.file_start ? 9'd0 : pend_reg;
    assign acc_new = {item.data_byte, acc_reg[31:8]};
    assign half    = acc_new[31:16];
    assign ch_bits = {16'd0, ch_reg} * {2'd0, bits_reg};

    always_comb
    begin
        case (ch_reg)
            2'd1:    min_byte_rate = {2'b00, rate_reg};
            2'd2:    min_byte_rate = {1'b0, rate_reg, 1'b0};
            default: min_byte_rate = '0;
        endcase
    end

    // one check per field, made on its last byte
    always_comb
    begin
        chk_err  = 1'b0;
        chk_code = ERR_RIFF_ID;
        case (pos_v)
            POS_RIFF_ID:
            begin
                chk_err  = (acc_new != TAG_RIFF);
                chk_code = ERR_RIFF_ID;
            end
            POS_CHUNK_SIZE:
            begin
                chk_err  = acc_new[31] || (acc_new < 32'd8);
                chk_code = ERR_CHUNK_SIZE;
            end
            POS_WAVE_ID:
            begin
                chk_err  = (acc_new != TAG_WAVE);
                chk_code = ERR_WAVE_ID;
            end
            POS_FMT_ID:
            begin
                chk_err  = (acc_new != TAG_FMT);
                chk_code = ERR_FMT_ID;
            end
            POS_FMT_SIZE:
            begin
                chk_err  = (acc_new != FMT_SIZE);
                chk_code = ERR_FMT_SIZE;
            end
            POS_AUDIO_FMT:
            begin
                chk_err  = (half != PCM_FMT);
                chk_code = ERR_AUDIO_FMT;
            end
            POS_CHANNELS:
            begin
                chk_err  = (half != 16'd1) && (half != 16'd2);
                chk_code = ERR_CHANNELS;
            end
            POS_RATE:
            begin
                chk_err  = (acc_new == 32'd0) || acc_new[31];
                chk_code = ERR_RATE;
            end
            POS_BYTE_RATE:
            begin
                chk_err  = acc_new[31] || ({1'b0, acc_new} < min_byte_rate);
                chk_code = ERR_BYTE_RATE;
            end
            POS_ALIGN:
            begin
                chk_err  = (half < {14'd0, ch_reg});
                chk_code = ERR_ALIGN;
            end
            POS_BITS:
            begin
                chk_err  = (half[15:3] > 13'd2);
                chk_code = ERR_BITS;
            end
            POS_DATA_ID:
            begin
                chk_err  = (acc_new != TAG_DATA);
                chk_code = ERR_DATA_ID;
            end
            POS_DATA_SIZE:
            begin
                chk_err  = acc_new[31] || (acc_new < {17'd0, ch_bits[17:3]});
                chk_code = ERR_DATA_SIZE;
            end
            default:
            begin
                chk_err  = 1'b0;
                chk_code = ERR_RIFF_ID;
            end
        endcase
    end

    assign size_even  = (bits_reg == BITS_8) ? acc_new[30:0] : {acc_new[30:1], 1'b0};
    assign remain_dec = (bits_reg == BITS_8) ? (remain_reg - 31'd1) : (remain_reg - 31'd2);

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        ch_next     = ch_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        remain_next = remain_reg;
        pend_next   = pend_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (step)
        begin
            phase_next = phase_v;
            pos_next   = pos_v;
            pend_next  = pend_v;
            case (phase_v)
                PH_HEADER:
                begin
                    acc_next = acc_new;
                    if (chk_err)
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = chk_code;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        if (pos_v == POS_CHANNELS)
                            ch_next = half[1:0];
                        if (pos_v == POS_RATE)
                            rate_next = acc_new[30:0];
                        if (pos_v == POS_BITS)
                            bits_next = half;
                        if (pos_v == POS_DATA_SIZE)
                        begin
                            res_valid         = 1'b1;
                            res.result_kind   = KIND_HEADER;
                            res.channel_count = ch_reg;
                            res.rate_hz       = rate_reg;
                            res.sample_bits   = bits_reg;
                            res.payload_bytes = acc_new[30:0];
                            remain_next       = size_even;
                            pend_next         = '0;
                            phase_next        = (size_even != '0) ? PH_DATA : PH_IDLE;
                        end
                        else
                            pos_next = pos_v + 6'd1;
                    end
                end
                PH_DATA:
                begin
                    if ((bits_reg != BITS_8) && !pend_v[8])
                        pend_next = {1'b1, item.data_byte};
                    else
                    begin
                        res_valid        = 1'b1;
                        res.result_kind  = KIND_SAMPLE;
                        res.sample_value = (bits_reg == BITS_8) ?
                                           {8'd0, item.data_byte} :
                                           {item.data_byte, pend_v[7:0]};
                        remain_next      = remain_dec;
                        pend_next        = '0;
                        if (remain_dec == '0)
                        begin
                            res.last_sample = 1'b1;
                            phase_next      = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_v;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            acc_reg    <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            remain_reg <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            ch_reg     <= ch_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

@@ rtl/core/wav_header_parser.sv @@
// ----------------------------------------------------------------------------
// wav_header_parser
// WAV RIFF/PCM header checker and sample extractor, one byte per request.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      in_item_t  (byte, start)
//   result    out        result_valid / result_ready  out_item_t (report,
//                                                     sample or error)
//
// One byte per cycle when result_ready stays high; each byte passes the
// input register, then parse logic into the result register.
// Throughput is set by the single parse stage between those registers.
// Reset clears all parser state; the parser idles until a start byte.
// A stalled result holds the parse stage; the input register takes one more.
// ----------------------------------------------------------------------------
module wav_header_parser
    import wvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic      in_vld_reg, in_vld_next;
    in_item_t  in_item_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_item_reg;
    logic      advance;
    logic      res_valid;
    out_item_t res;

    assign advance    = in_vld_reg && (!out_vld_reg || result_ready);
    assign item_ready = !in_vld_reg || advance;

    wvp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (item_ready)
            in_vld_next = item_valid;
        out_vld_next = out_vld_reg;
        if (advance && res_valid)
            out_vld_next = 1'b1;
        else if (result_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_item_reg <= item;
        if (advance && res_valid)
            out_item_reg <= res;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_item_reg;

endmodule
